// ===== rtl/pdve_pkg.sv =====
// ----------------------------------------------------------------------------
// pdve_pkg: shared definitions for the pose-difference velocity estimator
// Holds the fixed-point constants, the status codes, the sequencer state type,
// the CORDIC arctangent table and the angle wrap and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pdve_pkg;

    // Algorithm sizes.
    localparam int CORDIC_STEPS  = 16;
    localparam int POS_FRAC_BITS = 16;
    localparam int ITER_W        = 5;
    localparam int DIV_BITS      = 56;
    localparam int DIV_CNT_W     = 6;

    // Q4.12 angle constants and the CORDIC start gain in 2^-30 units.
    localparam logic signed [17:0] PI_Q12      = 18'sd12868;
    localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
    localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;

    // Result status codes.
    localparam logic [1:0] STATUS_FIRST   = 2'd0;
    localparam logic [1:0] STATUS_HELD    = 2'd1;
    localparam logic [1:0] STATUS_UPDATED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT,
        ST_MUL_C,
        ST_MUL_S,
        ST_NUM,
        ST_NUM_ADD,
        ST_LAUNCH,
        ST_DIV,
        ST_DONE
    } state_t;

    // Arctangent of 2^-i in 2^-30 rad units, truncated.
    function automatic logic signed [32:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [32:0] v;
        unique case (idx)
            5'd0:  v = 33'sd843314856;
            5'd1:  v = 33'sd497837829;
            5'd2:  v = 33'sd263043836;
            5'd3:  v = 33'sd133525158;
            5'd4:  v = 33'sd67021686;
            5'd5:  v = 33'sd33543515;
            5'd6:  v = 33'sd16775850;
            5'd7:  v = 33'sd8388437;
            5'd8:  v = 33'sd4194282;
            5'd9:  v = 33'sd2097149;
            5'd10: v = 33'sd1048575;
            5'd11: v = 33'sd524287;
            5'd12: v = 33'sd262143;
            5'd13: v = 33'sd131071;
            5'd14: v = 33'sd65535;
            5'd15: v = 33'sd32767;
            5'd16: v = 33'sd16383;
            5'd17: v = 33'sd8191;
            5'd18: v = 33'sd4095;
            5'd19: v = 33'sd2047;
            5'd20: v = 33'sd1023;
            5'd21: v = 33'sd511;
            5'd22: v = 33'sd255;
            5'd23: v = 33'sd127;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // Wrap an angle in Q4.12 into [-pi, pi]; three steps cover any 18-bit input
    // that is a difference of two 16-bit headings.
    function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] v;
        v = a;
        for (int k = 0; k < 3; k++) begin
            if (v > PI_Q12) begin
                v = v - TWO_PI_Q12;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (v < -PI_Q12) begin
                v = v + TWO_PI_Q12;
            end
        end
        return v;
    endfunction

    // Apply a sign to a quotient magnitude and clamp to 32-bit two's complement.
    function automatic logic [31:0] signed_sat(input logic neg, input logic big,
                                               input logic [30:0] mag);
        logic [31:0] v;
        if (neg) begin
            v = big ? 32'h8000_0000 : (32'd0 - {1'b0, mag});
        end else begin
            v = big ? 32'h7FFF_FFFF : {1'b0, mag};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pdve_div.sv =====
// ----------------------------------------------------------------------------
// pdve_div: bit-serial restoring divider
// Shifts one numerator bit into the partial remainder per cycle and keeps
// the low 31 quotient bits plus a flag for any quotient of 2^31 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module pdve_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pdve_pkg::DIV_BITS-1:0] numer,
    input  wire logic [31:0]                   denom,
    output logic                               busy,
    output logic [30:0]                        quot,
    output logic                               big
);
    import pdve_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]   num_reg, num_next;
    logic [31:0]           den_reg, den_next;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           q_reg, q_next;
    logic                  ovf_reg, ovf_next;
    logic [32:0]           trial;
    logic [32:0]           diff;

    // One restoring step per cycle.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        trial     = {rem_reg, num_reg[DIV_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_BITS - 1);
            num_next  = numer;
            den_next  = denom;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            num_next = {num_reg[DIV_BITS-2:0], 1'b0};
            ovf_next = ovf_reg | q_reg[31];
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg[30:0];
    assign big  = ovf_reg | q_reg[31];

endmodule

`default_nettype wire

// ===== rtl/pose_difference_velocity_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// pose_difference_velocity_estimator_unit: velocity from pose differences
// Estimates forward speed and turn rate from successive timestamped poses.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_       in         pose sample: x, y, heading, stamp (tdata)
//  m_       out        pose, forward speed, turn rate (tdata), status (tuser)
//
// A first sample or a bad time step goes from idle straight to the done state.
// An updated sample passes the preparation state, CORDIC_STEPS rotation steps
// (the CORDIC rotates one step a cycle) and the multiply and numerator states;
// then two bit-serial dividers run in parallel over DIV_BITS numerator bits. A new request is
// taken as soon as the previous result sits in the output register, even if
// the sink stalls it. Reset clears the stored pose, stamp and held speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_difference_velocity_estimator_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // x_position[31:0], y_position[63:32], heading[79:64], stamp_us[111:80]
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pose_x[31:0], pose_y[63:32], pose_heading[79:64],
    // forward_speed[111:80], turn_rate[143:112]
    output logic [143:0]      m_tdata,
    // status[1:0]
    output logic [1:0]        m_tuser
);
    import pdve_pkg::*;

    state_t state_reg, state_next;

    // Stored state from the last first-sample or updated pose.
    logic               have_prev_reg;
    logic signed [31:0] last_x_reg, last_y_reg;
    logic signed [15:0] last_h_reg;
    logic [31:0]        last_stamp_reg;
    logic [31:0]        held_fwd_reg, held_turn_reg;

    // Current request.
    logic signed [31:0] in_x_reg, in_y_reg;
    logic signed [15:0] in_h_reg;
    logic [31:0]        in_stamp_reg;
    logic [1:0]         status_reg;

    // Working registers.
    logic [31:0]        dt_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [17:0] dth_reg;
    logic signed [15:0] oh_reg;
    logic               fold_neg_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic signed [59:0] prod_reg;
    logic signed [60:0] p_reg;
    logic [49:0]        lo_prod_reg, hi_prod_reg;
    logic [DIV_BITS-1:0] turn_num_reg, spd_num_reg;
    logic               p_neg_reg;

    logic               m_tvalid_reg;
    logic [143:0]       m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic               accept;
    logic               out_free;
    logic               div_start;
    logic               spd_busy, turn_busy;
    logic [30:0]        spd_quot, turn_quot;
    logic               spd_big, turn_big;

    logic signed [31:0] s_x, s_y;
    logic signed [15:0] s_h;
    logic [31:0]        s_stamp;

    // Preparation-stage values.
    logic signed [17:0] oh_w, fold_w, dth_w;
    logic               fold_neg_w;

    // CORDIC step.
    logic signed [32:0] xs_w, ys_w;

    // Multiply stage values.
    logic signed [32:0] cxn_w, cyn_w;
    logic signed [26:0] cos_w, sin_w;
    logic signed [59:0] prod_s_w;
    logic [60:0]        pmag_w;
    logic [16:0]        tmag_w;
    logic [63:0]        turn_wide_w;
    logic [79:0]        spd_sum_w;

    assign s_x     = s_tdata[31:0];
    assign s_y     = s_tdata[63:32];
    assign s_h     = s_tdata[79:64];
    assign s_stamp = s_tdata[111:80];

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == ST_LAUNCH);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (have_prev_reg && (s_stamp > last_stamp_reg)) begin
                        state_next = ST_PREP;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PREP:    state_next = ST_ROT;
            ST_ROT: begin
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_MUL_C;
                end
            end
            ST_MUL_C:   state_next = ST_MUL_S;
            ST_MUL_S:   state_next = ST_NUM;
            ST_NUM:     state_next = ST_NUM_ADD;
            ST_NUM_ADD: state_next = ST_LAUNCH;
            ST_LAUNCH:  state_next = ST_DIV;
            ST_DIV: begin
                if (!spd_busy && !turn_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Angle preparation: wrap, fold into [-pi/2, pi/2].
    always_comb begin
        oh_w       = wrap_angle(18'(in_h_reg));
        dth_w      = wrap_angle(18'(in_h_reg) - 18'(last_h_reg));
        fold_w     = oh_w;
        fold_neg_w = 1'b0;
        if (oh_w > HALF_PI_Q12) begin
            fold_w     = oh_w - PI_Q12;
            fold_neg_w = 1'b1;
        end else if (oh_w < -HALF_PI_Q12) begin
            fold_w     = oh_w + PI_Q12;
            fold_neg_w = 1'b1;
        end
    end

    assign xs_w = cx_reg >>> iter_reg;
    assign ys_w = cy_reg >>> iter_reg;

    // Projection and numerator arithmetic.
    always_comb begin
        cxn_w       = fold_neg_reg ? -cx_reg : cx_reg;
        cyn_w       = fold_neg_reg ? -cy_reg : cy_reg;
        cos_w       = 27'(cxn_w >>> 6);
        sin_w       = 27'(cyn_w >>> 6);
        prod_s_w    = sin_w * dy_reg;
        pmag_w      = p_reg[60] ? 61'(-p_reg) : 61'(p_reg);
        tmag_w      = dth_reg[17] ? 17'(-dth_reg) : 17'(dth_reg);
        turn_wide_w = ((64'(tmag_w) * 64'(USEC_PER_SEC)) << POS_FRAC_BITS) >> 12;
        spd_sum_w   = 80'(lo_prod_reg) + (80'(hi_prod_reg) << 30);
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_x_reg     <= s_x;
            in_y_reg     <= s_y;
            in_h_reg     <= s_h;
            in_stamp_reg <= s_stamp;
        end
        unique case (state_reg)
            ST_PREP: begin
                dt_reg       <= in_stamp_reg - last_stamp_reg;
                dx_reg       <= 33'(in_x_reg) - 33'(last_x_reg);
                dy_reg       <= 33'(in_y_reg) - 33'(last_y_reg);
                dth_reg      <= dth_w;
                oh_reg       <= 16'(oh_w);
                fold_neg_reg <= fold_neg_w;
                cx_reg       <= CORDIC_GAIN;
                cy_reg       <= '0;
                cz_reg       <= 33'(fold_w) <<< 18;
                iter_reg     <= '0;
            end
            ST_ROT: begin
                if (!cz_reg[32]) begin
                    cx_reg <= cx_reg - ys_w;
                    cy_reg <= cy_reg + xs_w;
                    cz_reg <= cz_reg - atan_entry(iter_reg);
                end else begin
                    cx_reg <= cx_reg + ys_w;
                    cy_reg <= cy_reg - xs_w;
                    cz_reg <= cz_reg + atan_entry(iter_reg);
                end
                iter_reg <= iter_reg + 1'b1;
            end
            ST_MUL_C: prod_reg <= cos_w * dx_reg;
            ST_MUL_S: p_reg <= 61'(prod_reg) + 61'(prod_s_w);
            ST_NUM: begin
                p_neg_reg    <= p_reg[60];
                lo_prod_reg  <= 50'(pmag_w[29:0]) * 50'(USEC_PER_SEC);
                hi_prod_reg  <= 50'(pmag_w[59:30]) * 50'(USEC_PER_SEC);
                turn_num_reg <= turn_wide_w[DIV_BITS-1:0];
            end
            ST_NUM_ADD: spd_num_reg <= spd_sum_w[79:24];
            default: ;
        endcase
    end

    // Stored pose and held speeds.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg  <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_h_reg     <= '0;
            last_stamp_reg <= '0;
            held_fwd_reg   <= '0;
            held_turn_reg  <= '0;
            status_reg     <= STATUS_FIRST;
        end else begin
            if (accept) begin
                if (!have_prev_reg) begin
                    have_prev_reg  <= 1'b1;
                    last_x_reg     <= s_x;
                    last_y_reg     <= s_y;
                    last_h_reg     <= s_h;
                    last_stamp_reg <= s_stamp;
                    held_fwd_reg   <= '0;
                    held_turn_reg  <= '0;
                    status_reg     <= STATUS_FIRST;
                end else if (s_stamp <= last_stamp_reg) begin
                    status_reg <= STATUS_HELD;
                end else begin
                    status_reg <= STATUS_UPDATED;
                end
            end
            if ((state_reg == ST_DIV) && !spd_busy && !turn_busy) begin
                held_fwd_reg   <= signed_sat(p_neg_reg, spd_big, spd_quot);
                held_turn_reg  <= signed_sat(dth_reg[17], turn_big, turn_quot);
                last_x_reg     <= in_x_reg;
                last_y_reg     <= in_y_reg;
                last_h_reg     <= in_h_reg;
                last_stamp_reg <= in_stamp_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {held_turn_reg, held_fwd_reg,
                            (status_reg == STATUS_UPDATED) ? oh_reg : in_h_reg,
                            in_y_reg, in_x_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Forward speed: floor(|p| * 10^6 / 2^24) / dt.
    pdve_div u_spd_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (spd_num_reg),
        .denom   (dt_reg),
        .busy    (spd_busy),
        .quot    (spd_quot),
        .big     (spd_big)
    );

    // Turn rate: |dtheta| * 10^6 * 2^(frac - 12) / dt.
    pdve_div u_turn_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (turn_num_reg),
        .denom   (dt_reg),
        .busy    (turn_busy),
        .quot    (turn_quot),
        .big     (turn_big)
    );

endmodule

`default_nettype wire

// ===== rtl/pdve_checker.sv =====
// ----------------------------------------------------------------------------
// pdve_checker: port-level checks for the velocity estimator
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pdve_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata,
    input wire logic [1:0]   m_tuser
);
    import pdve_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_FIRST || m_tuser == STATUS_HELD ||
                      m_tuser == STATUS_UPDATED))
        else $error("undefined status code");

    // A first-sample result carries zero speeds.
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_FIRST) |->
            (m_tdata[111:80] == 32'd0) && (m_tdata[143:112] == 32'd0))
        else $error("first sample with nonzero speed");

    // No request is taken in the cycle right after one was taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind pose_difference_velocity_estimator_unit pdve_checker u_pdve_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/pose_difference_velocity_estimator_unit_test.sv =====
// ----------------------------------------------------------------------------
// pose_difference_velocity_estimator_unit_test: regression for the estimator
// Drives pose samples over the input stream, predicts each result with a
// bit-accurate software model of the CORDIC and dividers, and checks every
// result on the output stream field by field, under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_difference_velocity_estimator_unit_test;
    import pdve_pkg::*;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] ph;
        logic [31:0] fwd;
        logic [31:0] turn;
        logic [1:0]  status;
    } pose_result_t;

    // Bit-accurate predictor of the estimator, with its own copy of the state.
    class velocity_scoreboard;
        bit                 primed;
        longint             prev_x, prev_y, prev_h;
        longint unsigned    prev_stamp;
        longint             hold_fwd, hold_turn;
        pose_result_t       pending[$];
        int                 errors;

        function new();
            primed = 0; prev_x = 0; prev_y = 0; prev_h = 0; prev_stamp = 0;
            hold_fwd = 0; hold_turn = 0; errors = 0;
        endfunction

        function longint wrap(longint a);
            while (a > 12868) a -= 25736;
            while (a < -12868) a += 25736;
            return a;
        endfunction

        function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        function longint atan_of(int i);
            longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
                255, 127};
            return t[i];
        endfunction

        // Restoring division of a 128-bit numerator, quotient capped at 2^33.
        function longint unsigned quotient(logic [127:0] num, longint unsigned den);
            longint unsigned rem, q;
            rem = 0; q = 0;
            for (int i = 127; i >= 0; i--) begin
                rem = (rem << 1) | num[i];
                q = q << 1;
                if (rem >= den) begin
                    rem -= den; q |= 1;
                end
                if (q > (64'd1 << 33)) q = 64'd1 << 33;
            end
            return q;
        endfunction

        function longint saturate(bit neg, longint unsigned mag);
            if (neg) return (mag >= (64'd1 << 31)) ? -(64'sd1 << 31) : -longint'(mag);
            return (mag > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(mag);
        endfunction

        // Note an accepted request and queue the result it must produce.
        function void note_request(logic [111:0] d);
            longint nx, ny, nh, oh, dx, dy, dth, cx, sy, z, xs, ys, p;
            longint unsigned st, dt, mag;
            bit flip;
            logic [1:0] status;
            logic [127:0] num;
            pose_result_t r;
            nx = longint'($signed(d[31:0]));
            ny = longint'($signed(d[63:32]));
            nh = longint'($signed(d[79:64]));
            st = d[111:80];
            oh = nh;
            if (!primed) begin
                primed = 1; prev_x = nx; prev_y = ny; prev_h = nh; prev_stamp = st;
                hold_fwd = 0; hold_turn = 0; status = STATUS_FIRST;
            end else if (st <= prev_stamp) begin
                status = STATUS_HELD;
            end else begin
                dt = st - prev_stamp;
                dx = nx - prev_x; dy = ny - prev_y;
                dth = wrap(nh - prev_h);
                oh = wrap(nh);
                z = oh; flip = 0;
                if (z > 6434) begin
                    z -= 12868; flip = 1;
                end else if (z < -6434) begin
                    z += 12868; flip = 1;
                end
                z = z * 262144; cx = 652032874; sy = 0;
                for (int i = 0; i < CORDIC_STEPS; i++) begin
                    xs = asr(cx, i); ys = asr(sy, i);
                    if (z >= 0) begin
                        cx -= ys; sy += xs; z -= atan_of(i);
                    end else begin
                        cx += ys; sy -= xs; z += atan_of(i);
                    end
                end
                if (flip) begin
                    cx = -cx; sy = -sy;
                end
                cx = asr(cx, 6); sy = asr(sy, 6);
                p = cx * dx + sy * dy;
                mag = (p < 0) ? longint'(-p) : p;
                num = 128'(mag) * 128'(1000000);
                hold_fwd = saturate(p < 0, quotient(num, dt << 24));
                mag = (dth < 0) ? -dth : dth;
                num = 128'((mag * 1000000) << POS_FRAC_BITS);
                hold_turn = saturate(dth < 0, quotient(num, dt << 12));
                prev_x = nx; prev_y = ny; prev_h = nh; prev_stamp = st;
                status = STATUS_UPDATED;
            end
            r.px = nx[31:0]; r.py = ny[31:0]; r.ph = oh[15:0];
            r.fwd = hold_fwd[31:0]; r.turn = hold_turn[31:0]; r.status = status;
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest queued one.
        function void check_result(logic [143:0] d, logic [1:0] u);
            pose_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%0d", d, u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.px) begin
                $error("pose_x expected %h got %h", e.px, d[31:0]); errors++;
            end
            if (d[63:32] !== e.py) begin
                $error("pose_y expected %h got %h", e.py, d[63:32]); errors++;
            end
            if (d[79:64] !== e.ph) begin
                $error("pose_heading expected %h got %h", e.ph, d[79:64]); errors++;
            end
            if (d[111:80] !== e.fwd) begin
                $error("forward_speed expected %h got %h", e.fwd, d[111:80]); errors++;
            end
            if (d[143:112] !== e.turn) begin
                $error("turn_rate expected %h got %h", e.turn, d[143:112]); errors++;
            end
            if (u !== e.status) begin
                $error("status expected %0d got %0d", e.status, u); errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;

    velocity_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    longint cycles = 0;
    logic [31:0] clock_us = 0;
    logic [31:0] cur_x = 0, cur_y = 0;
    logic [15:0] cur_h = 0;

    pose_difference_velocity_estimator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Sample results at the rising edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver stalls change at the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one pose request, with a random gap before it. The valid line is
    // dropped in idle cycles and after the last request.
    task automatic send_pose(logic [31:0] x, logic [31:0] y, logic [15:0] h,
                             logic [31:0] st);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {st, h, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request({st, h, y, x});
        @(negedge aclk);
    endtask

    // Random item: mostly a plausible trajectory, sometimes raw noise or a repeated or stale stamp.
    task automatic send_random();
        int k;
        k = $urandom_range(99);
        if (k < 8) begin
            send_pose($urandom, $urandom, 16'($urandom), $urandom);
        end else if (k < 16) begin
            send_pose(cur_x + $urandom_range(2000) - 1000, cur_y, cur_h,
                      clock_us - $urandom_range(3));
        end else begin
            cur_x = cur_x + $signed($urandom_range(400000)) - 200000;
            cur_y = cur_y + $signed($urandom_range(400000)) - 200000;
            cur_h = (k < 22) ? 16'($urandom)
                             : 16'(cur_h + $urandom_range(1200) - 600);
            clock_us = clock_us + ((k < 26) ? $urandom_range(3) + 1
                                            : $urandom_range(200000) + 1);
            send_pose(cur_x, cur_y, cur_h, clock_us);
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // Directed: first sample, bad steps, extremes, wraps and saturation.
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 32'd100);
        send_pose(0, 0, 16'd0, 32'd100);
        send_pose(0, 0, 16'd0, 32'd50);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 32'd101);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'd12868, 32'd102);
        send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hCDBC, 32'hFFFF_FFFF);
        send_pose(0, 0, 16'd0, 32'd0);
        send_pose(32'd65536, 0, 16'd6434, 32'hFFFF_FFFF);
        clock_us = 32'd1000;
        send_pose(0, 0, 16'd0, clock_us);
        clock_us += 1000000; send_pose(32'd65536, 0, 16'd0, clock_us);
        clock_us += 1; send_pose(32'd65536, 32'd65536, 16'd6435, clock_us);
        clock_us += 1; send_pose(0, 32'd65536, 16'hE6BD, clock_us);
        clock_us += 100; send_pose(0, 0, 16'd12869, clock_us);
        clock_us += 7; send_pose(32'hFFFF0000, 0, 16'hCDBB, clock_us);
        clock_us += 3; send_pose(32'hFFFF0000, 0, 16'h8000, clock_us);
        clock_us += 20000; send_pose(32'h5555_AAAA, 32'hAAAA_5555, 16'h7FFF, clock_us);
        // Random phases with different stall mixes.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 49 : 0;
            recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 34 : 0;
            repeat (430) send_random();
        end
        s_tvalid <= 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

`default_nettype wire
